// ----- rtl/point_cloud_to_scan_binner_macros.svh -----
// assertion macros shared by the scan binner checker
// no dependencies; included by the checker file
`ifndef POINT_CLOUD_TO_SCAN_BINNER_MACROS_SVH
`define POINT_CLOUD_TO_SCAN_BINNER_MACROS_SVH

// property checked outside reset
`define PCSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every edge, reset included
`define PCSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/pcsb_pkg.sv -----
// types, codes and constants of the scan binner
// no dependencies
package pcsb_pkg;

  // result status codes
  localparam logic [2:0] ST_LOWERED = 3'd0;
  localparam logic [2:0] ST_KEPT    = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_HEIGHT  = 3'd3;
  localparam logic [2:0] ST_NEAR    = 3'd4;
  localparam logic [2:0] ST_FAR     = 3'd5;
  localparam logic [2:0] ST_ANGLE   = 3'd6;
  localparam logic [2:0] ST_READOUT = 3'd7;

  // register indexes
  localparam logic [2:0] REG_MIN_HEIGHT = 3'd0;
  localparam logic [2:0] REG_MAX_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RANGE_MIN  = 3'd2;
  localparam logic [2:0] REG_RANGE_MAX  = 3'd3;
  localparam logic [2:0] REG_ANGLE_MIN  = 3'd4;
  localparam logic [2:0] REG_ANGLE_MAX  = 3'd5;
  localparam logic [2:0] REG_ANGLE_INC  = 3'd6;
  localparam logic [2:0] REG_NO_RETURN  = 3'd7;

  // register reset values
  localparam logic [23:0] RST_MIN_HEIGHT = 24'h800000;
  localparam logic [23:0] RST_MAX_HEIGHT = 24'h7FFFFF;
  localparam logic [23:0] RST_RANGE_MIN  = 24'h000000;
  localparam logic [23:0] RST_RANGE_MAX  = 24'hFFFFFE;
  localparam logic [15:0] RST_ANGLE_MIN  = 16'h8000;
  localparam logic [15:0] RST_ANGLE_MAX  = 16'h7FFF;
  localparam logic [15:0] RST_ANGLE_INC  = 16'd182;
  localparam logic [23:0] RST_NO_RETURN  = 24'hFFFFFF;

  // bin store address width, enough for the largest bin count
  localparam int unsigned BIN_ADDR_W = 12;
  localparam int unsigned CORDIC_STEPS = 18;

  // bin store access from the sequencer
  typedef struct packed {
    logic                  rd_en;
    logic                  wr_en;
    logic [BIN_ADDR_W-1:0] addr;
    logic [23:0]           wr_data;
  } mem_req_t;

  // arctangent of 2^-i in units of pi/2^20
  function automatic logic [18:0] atan_entry(input logic [4:0] i);
    logic [18:0] v;
    case (i)
      5'd0:  v = 19'd262144;
      5'd1:  v = 19'd154753;
      5'd2:  v = 19'd81767;
      5'd3:  v = 19'd41506;
      5'd4:  v = 19'd20834;
      5'd5:  v = 19'd10427;
      5'd6:  v = 19'd5215;
      5'd7:  v = 19'd2608;
      5'd8:  v = 19'd1304;
      5'd9:  v = 19'd652;
      5'd10: v = 19'd326;
      5'd11: v = 19'd163;
      5'd12: v = 19'd81;
      5'd13: v = 19'd41;
      5'd14: v = 19'd20;
      5'd15: v = 19'd10;
      5'd16: v = 19'd5;
      5'd17: v = 19'd3;
      default: v = 19'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/pcsb_if.sv -----
// channel interfaces of the scan binner: point/command in, result out, config
// no dependencies

interface pcsb_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic               coord_invalid;
  logic [8:0]         read_bin;
  modport source (output valid, cmd, pos_x, pos_y, pos_z, coord_invalid, read_bin,
                  input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, pos_z, coord_invalid, read_bin,
                  output ready);
endinterface

interface pcsb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [23:0] range_value;
  logic [8:0]  bin_index;
  modport source (output valid, status, range_value, bin_index, input ready);
  modport sink   (input valid, status, range_value, bin_index, output ready);
endinterface

interface pcsb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/pcsb_bin_mem.sv -----
// bin range store: single port memory with registered read and a clearing pass
// depends on pcsb_pkg
module pcsb_bin_mem #(
  parameter int unsigned NUM_BINS = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcsb_pkg::mem_req_t req_i,
  output logic [23:0]       rd_data_o,
  output logic              clear_done_o
);
  import pcsb_pkg::*;

  localparam int unsigned BW = $clog2(NUM_BINS);

  logic [23:0] mem_q [NUM_BINS];
  logic [BW:0] clr_cnt_q, clr_cnt_d;
  logic        clearing;
  logic        wr_en;
  logic [BW-1:0] wr_addr;
  logic [23:0] wr_data;

  // clearing pass after reset, one entry per cycle
  assign clearing  = (clr_cnt_q != (BW+1)'(NUM_BINS));
  assign clr_cnt_d = clearing ? clr_cnt_q + 1'b1 : clr_cnt_q;
  assign clear_done_o = !clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // write port shared by the clearing pass and the sequencer
  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q[BW-1:0];
      wr_data = RST_NO_RETURN;
    end else begin
      wr_en   = req_i.wr_en;
      wr_addr = req_i.addr[BW-1:0];
      wr_data = req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.addr[BW-1:0]];
    end
  end

endmodule

// ----- rtl/pcsb_core.sv -----
// sequencer and shared arithmetic of the scan binner: squares, square root,
// cordic, bin divider, config registers and result register; uses pcsb_pkg
module pcsb_core #(
  parameter int unsigned NUM_BINS = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pcsb_in_if.sink            in_i,
  pcsb_out_if.source         out_o,
  pcsb_cfg_if.sink           cfg_i,
  output pcsb_pkg::mem_req_t mem_req_o,
  input  logic [23:0]        mem_rd_data_i,
  input  logic               clear_done_i
);
  import pcsb_pkg::*;

  localparam logic [16:0] NB17 = 17'(NUM_BINS);

  // sequencer state codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_RMIN = 4'd3;
  localparam logic [3:0] S_RMAX = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_CORD = 4'd7;
  localparam logic [3:0] S_ANG  = 4'd8;
  localparam logic [3:0] S_DIVN = 4'd9;
  localparam logic [3:0] S_DIVI = 4'd10;
  localparam logic [3:0] S_RD   = 4'd11;
  localparam logic [3:0] S_UPD  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  // config registers
  logic signed [23:0] min_h_q, max_h_q;
  logic [23:0]        rmin_q, rmax_q, noret_q;
  logic signed [15:0] amin_q, amax_q;
  logic [15:0]        inc_q;

  // item registers
  logic               cmd_q;
  logic signed [23:0] x_q, y_q;
  logic [8:0]         rb_q;

  // datapath registers
  logic [47:0]        sq_q, rmin2_q, rmax2_q, rad_q;
  logic [25:0]        rem_q;
  logic [23:0]        root_q;
  logic signed [47:0] cx_q, cy_q;
  logic signed [21:0] cz_q;
  logic               spec_q;
  logic [15:0]        spec_val_q;
  logic signed [17:0] ang_q;
  logic [16:0]        dnum_q, dquo_q, nb_q;
  logic [15:0]        drem_q;
  logic [16:0]        idx_q;
  logic               rb_ok_q;

  // staged and output results
  logic [2:0]  res_status_q;
  logic [23:0] res_range_q;
  logic [8:0]  res_bin_q;
  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [23:0] out_range_q;
  logic [8:0]  out_bin_q;

  logic in_acc, out_free;
  assign in_i.ready  = (state_q == S_IDLE) && clear_done_i;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_h_q <= RST_MIN_HEIGHT;
      max_h_q <= RST_MAX_HEIGHT;
      rmin_q  <= RST_RANGE_MIN;
      rmax_q  <= RST_RANGE_MAX;
      amin_q  <= RST_ANGLE_MIN;
      amax_q  <= RST_ANGLE_MAX;
      inc_q   <= RST_ANGLE_INC;
      noret_q <= RST_NO_RETURN;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MIN_HEIGHT: min_h_q <= cfg_i.data;
        REG_MAX_HEIGHT: max_h_q <= cfg_i.data;
        REG_RANGE_MIN:  rmin_q  <= cfg_i.data;
        REG_RANGE_MAX:  rmax_q  <= cfg_i.data;
        REG_ANGLE_MIN:  amin_q  <= cfg_i.data[15:0];
        REG_ANGLE_MAX:  amax_q  <= cfg_i.data[15:0];
        REG_ANGLE_INC:  inc_q   <= cfg_i.data[15:0];
        REG_NO_RETURN:  noret_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // shared squaring multiplier
  logic signed [24:0] mul_op;
  logic signed [49:0] prod;
  logic [47:0]        p48;
  always_comb begin
    case (state_q)
      S_SQX:   mul_op = 25'(x_q);
      S_SQY:   mul_op = 25'(y_q);
      S_RMIN:  mul_op = $signed({1'b0, rmin_q});
      default: mul_op = $signed({1'b0, rmax_q});
    endcase
  end
  assign prod = mul_op * mul_op;
  assign p48  = prod[47:0];

  // square root step, two radicand bits per cycle
  logic [27:0] sq_rsh, sq_trial;
  logic        sq_ge;
  assign sq_rsh   = {rem_q, rad_q[47:46]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_rsh >= sq_trial;

  // folded magnitudes
  logic signed [24:0] xe, ye;
  logic [23:0]        ax, ay;
  assign xe = 25'(x_q);
  assign ye = 25'(y_q);
  assign ax = x_q[23] ? 24'(-xe) : x_q;
  assign ay = y_q[23] ? 24'(-ye) : y_q;

  // cordic vectoring step
  logic signed [47:0] c_dx, c_dy;
  logic signed [21:0] c_at;
  assign c_dx = cy_q >>> cnt_q;
  assign c_dy = cx_q >>> cnt_q;
  assign c_at = $signed({3'b000, atan_entry(cnt_q)});

  // angle rounding, quadrant restore and window
  logic [19:0]        zc, zr;
  logic [15:0]        afold;
  logic signed [17:0] abase, ang, amin18, amax18, span18, off18;
  logic               ang_bad;
  always_comb begin
    if (cz_q < 0) begin
      zc = '0;
    end else if (cz_q > 22'sd524288) begin
      zc = 20'd524288;
    end else begin
      zc = cz_q[19:0];
    end
    zr     = zc + 20'd8;
    afold  = spec_q ? spec_val_q : zr[19:4];
    abase  = x_q[23] ? 18'sd32768 - $signed({2'b00, afold}) : $signed({2'b00, afold});
    ang    = y_q[23] ? -abase : abase;
    amin18 = 18'(amin_q);
    amax18 = 18'(amax_q);
    ang_bad = (ang < amin18) || (ang > amax18);
    span18 = amax18 - amin18;
    off18  = ang_q - amin18;
  end

  // divider step and bin count
  logic [15:0] incd;
  logic [16:0] d_rsh, nb_num;
  logic        d_ge;
  assign incd   = (inc_q == '0) ? 16'd1 : inc_q;
  assign nb_num = span18[16:0] + {1'b0, incd} - 17'd1;
  assign d_rsh  = {drem_q, dnum_q[16]};
  assign d_ge   = d_rsh >= {1'b0, incd};

  // last bin and clamped index
  logic [16:0] nbc, last_bin, idx_cl;
  always_comb begin
    if (nb_q == '0) begin
      nbc = 17'd1;
    end else if (nb_q > NB17) begin
      nbc = NB17;
    end else begin
      nbc = nb_q;
    end
    last_bin = nbc - 17'd1;
    idx_cl   = (dquo_q > last_bin) ? last_bin : dquo_q;
  end

  // bin store access
  always_comb begin
    mem_req_o = '0;
    if (state_q == S_RD) begin
      mem_req_o.rd_en = cmd_q ? ({8'd0, rb_q} < NB17) : 1'b1;
      mem_req_o.addr  = cmd_q ? BIN_ADDR_W'({3'd0, rb_q}) : idx_cl[BIN_ADDR_W-1:0];
    end else if (state_q == S_UPD) begin
      mem_req_o.addr = cmd_q ? BIN_ADDR_W'({3'd0, rb_q}) : idx_q[BIN_ADDR_W-1:0];
      if (cmd_q) begin
        mem_req_o.wr_en   = rb_ok_q;
        mem_req_o.wr_data = noret_q;
      end else begin
        mem_req_o.wr_en   = root_q < mem_rd_data_i;
        mem_req_o.wr_data = root_q;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          if (in_i.cmd) begin
            state_d = S_RD;
          end else if (in_i.coord_invalid || (in_i.pos_z > max_h_q) ||
                       (in_i.pos_z < min_h_q)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SQX;
          end
        end
      end
      S_SQX:  state_d = S_SQY;
      S_SQY:  state_d = S_RMIN;
      S_RMIN: state_d = S_RMAX;
      S_RMAX: state_d = S_SQRT;
      S_SQRT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd23) begin
          state_d = S_CHK;
          cnt_d   = '0;
        end
      end
      S_CHK: begin
        if ((sq_q < rmin2_q) || (sq_q > rmax2_q)) begin
          state_d = S_DONE;
        end else if ((ay == '0) || (ax == '0)) begin
          state_d = S_ANG;
        end else begin
          state_d = S_CORD;
        end
      end
      S_CORD: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
          state_d = S_ANG;
          cnt_d   = '0;
        end
      end
      S_ANG:  state_d = ang_bad ? S_DONE : S_DIVN;
      S_DIVN: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          state_d = S_DIVI;
          cnt_d   = '0;
        end
      end
      S_DIVI: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          state_d = S_RD;
          cnt_d   = '0;
        end
      end
      S_RD:   state_d = S_UPD;
      S_UPD:  state_d = S_DONE;
      S_DONE: state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_q        <= in_i.cmd;
          x_q          <= in_i.pos_x;
          y_q          <= in_i.pos_y;
          rb_q         <= in_i.read_bin;
          res_range_q  <= '0;
          res_bin_q    <= '0;
          res_status_q <= in_i.coord_invalid ? ST_INVALID : ST_HEIGHT;
        end
      end
      S_SQX: sq_q <= p48;
      S_SQY: sq_q <= sq_q + p48;
      S_RMIN: rmin2_q <= p48;
      S_RMAX: begin
        rmax2_q <= p48;
        rad_q   <= sq_q;
        rem_q   <= '0;
        root_q  <= '0;
      end
      S_SQRT: begin
        rad_q  <= {rad_q[45:0], 2'b00};
        rem_q  <= sq_ge ? 26'(sq_rsh - sq_trial) : sq_rsh[25:0];
        root_q <= {root_q[22:0], sq_ge};
      end
      S_CHK: begin
        res_range_q <= root_q;
        res_status_q <= (sq_q < rmin2_q) ? ST_NEAR : ST_FAR;
        spec_q     <= (ay == '0) || (ax == '0);
        spec_val_q <= (ay == '0) ? 16'd0 : 16'd16384;
        cx_q <= $signed({4'd0, ax, 20'd0});
        cy_q <= $signed({4'd0, ay, 20'd0});
        cz_q <= '0;
      end
      S_CORD: begin
        if (!cy_q[47]) begin
          cx_q <= cx_q + c_dx;
          cy_q <= cy_q - c_dy;
          cz_q <= cz_q + c_at;
        end else begin
          cx_q <= cx_q - c_dx;
          cy_q <= cy_q + c_dy;
          cz_q <= cz_q - c_at;
        end
      end
      S_ANG: begin
        res_status_q <= ST_ANGLE;
        ang_q  <= ang;
        dnum_q <= nb_num;
        drem_q <= '0;
        dquo_q <= '0;
      end
      S_DIVN, S_DIVI: begin
        if ((state_q == S_DIVN) && (cnt_q == 5'd16)) begin
          nb_q   <= {dquo_q[15:0], d_ge};
          dnum_q <= off18[16:0];
          drem_q <= '0;
          dquo_q <= '0;
        end else begin
          dnum_q <= {dnum_q[15:0], 1'b0};
          drem_q <= d_ge ? 16'(d_rsh - {1'b0, incd}) : d_rsh[15:0];
          dquo_q <= {dquo_q[15:0], d_ge};
        end
      end
      S_RD: begin
        idx_q   <= idx_cl;
        rb_ok_q <= {8'd0, rb_q} < NB17;
      end
      S_UPD: begin
        if (cmd_q) begin
          res_status_q <= ST_READOUT;
          res_range_q  <= rb_ok_q ? mem_rd_data_i : noret_q;
          res_bin_q    <= rb_q;
        end else begin
          res_status_q <= (root_q < mem_rd_data_i) ? ST_LOWERED : ST_KEPT;
          res_bin_q    <= idx_q[8:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && out_free) begin
      out_status_q <= res_status_q;
      out_range_q  <= res_range_q;
      out_bin_q    <= res_bin_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.range_value = out_range_q;
  assign out_o.bin_index   = out_bin_q;

endmodule

// ----- rtl/point_cloud_to_scan_binner.sv -----
// top level of the scan binner: sequencer core and bin range store
// depends on pcsb_pkg, pcsb_if, pcsb_core, pcsb_bin_mem
//
//  channel  dir  transaction
//  in_i     in   point (cmd 0) or readout of one bin (cmd 1)
//  out_o    out  one result per input transaction
//  cfg_i    in   register write, index and data, always ready
//
// a point that reaches the bin store passes from accept to result through
// four multiplier passes, 24 square root steps, 18 cordic steps, two 17 step
// divider passes, bin read, update and result staging (no cordic on an axis).
// early exits: invalid or height, near or far, angle window.
// a readout passes through the registered bin read, update and result staging.
// in_i is ready again in the same cycle that a result enters the output register.
// after reset the bin store is cleared one entry per cycle, NUM_BINS entries,
// and in_i is not ready until the pass is done.
// a result waits in the output register while out_o stalls; the next input
// transaction is taken meanwhile, and input stalls once that one is finished too.
module point_cloud_to_scan_binner #(
  parameter int unsigned NUM_BINS = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcsb_in_if.sink    in_i,
  pcsb_out_if.source out_o,
  pcsb_cfg_if.sink   cfg_i
);
  import pcsb_pkg::*;

  mem_req_t    mem_req;
  logic [23:0] mem_rd_data;
  logic        clear_done;

  pcsb_core #(
    .NUM_BINS(NUM_BINS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .cfg_i        (cfg_i),
    .mem_req_o    (mem_req),
    .mem_rd_data_i(mem_rd_data),
    .clear_done_i (clear_done)
  );

  pcsb_bin_mem #(
    .NUM_BINS(NUM_BINS)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mem_req),
    .rd_data_o   (mem_rd_data),
    .clear_done_o(clear_done)
  );

endmodule

// ----- rtl/pcsb_checker.sv -----
// port level checks of the scan binner, bound to the top level
// depends on pcsb_pkg and point_cloud_to_scan_binner_macros.svh
`include "point_cloud_to_scan_binner_macros.svh"

module pcsb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [23:0] out_range,
  input logic [8:0]  out_bin
);
  import pcsb_pkg::*;

  // a stalled result stays up
  `PCSB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // one transaction at a time
  `PCSB_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "input taken while busy")

  // no result in the cycle after a transaction is taken
  `PCSB_ASSERT(a_latency, in_valid && in_ready |=> !$rose(out_valid), "result too early")

  // early rejects carry no range and no bin
  `PCSB_ASSERT(a_reject, out_valid && (out_status == ST_INVALID || out_status == ST_HEIGHT) |-> out_range == 24'd0 && out_bin == 9'd0, "reject fields not zero")

  // nothing is shown once reset has been low for a full cycle
  `PCSB_ASSERT_ALWAYS(a_reset, !rst_ni ##1 !rst_ni |-> !out_valid && !in_ready, "activity in reset")

endmodule

bind point_cloud_to_scan_binner pcsb_checker u_pcsb_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_status(out_o.status),
  .out_range (out_o.range_value),
  .out_bin   (out_o.bin_index)
);
